// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define BSFE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BSFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// bsfe_pkg
// Types and constants of the byte stuffing frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int REG_IDX_W   = 3;

	// register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_FLAG      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ESCAPE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FLAG_SUB  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ESC_SUB   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ADDRESS   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CONTROL   = 3'd5;

	// register reset values
	localparam logic [BYTE_W-1:0] FLAG_RST     = 8'h7E;
	localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'h7D;
	localparam logic [BYTE_W-1:0] FLAG_SUB_RST = 8'h5E;
	localparam logic [BYTE_W-1:0] ESC_SUB_RST  = 8'h5D;
	localparam logic [BYTE_W-1:0] ADDRESS_RST  = 8'h03;
	localparam logic [BYTE_W-1:0] CONTROL_RST  = 8'h00;

	// header length in bytes
	localparam logic [CNT_W-1:0] HDR_LEN = CNT_W'(4);

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t flag_value;
		byte_t escape_value;
		byte_t flag_substitute;
		byte_t escape_substitute;
		byte_t address_value;
		byte_t control_value;
	} cfg_t;

	typedef struct packed {
		byte_t data_byte;
		logic  byte_present;
		logic  last_byte;
	} item_t;

	// burst of output bytes caused by one item
	typedef struct packed {
		byte_t [MAX_RESULTS-1:0] bytes;
		logic [IDX_W-1:0]        last_idx;
		logic                    nonempty;
		logic                    closes;
		logic                    hdr_sent_next;
	} burst_t;

endpackage

// File: design/bsfe_if.sv
// ----------------------------------------------------------------------------
// bsfe_if
// Valid/ready channels of the byte stuffing frame encoder.
// ----------------------------------------------------------------------------
interface bsfe_in_if;
	import bsfe_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  byte_present;
	logic  last_byte;

	modport source (output valid, data_byte, byte_present, last_byte, input ready);
	modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface bsfe_out_if;
	import bsfe_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  frame_end;
	logic  run_last;

	modport source (output valid, out_byte, frame_end, run_last, input ready);
	modport sink (input valid, out_byte, frame_end, run_last, output ready);
endinterface

// File: design/bsfe_build.sv
// ----------------------------------------------------------------------------
// bsfe_build
// Builds the list of framed bytes that one input item causes.
// ----------------------------------------------------------------------------
module bsfe_build
	import bsfe_pkg::*;
(
	input  cfg_t   cfg,
	input  item_t  item,
	input  logic   hdr_sent,
	output burst_t burst
);

	byte_t            check;
	logic [CNT_W-1:0] n;

	assign check = cfg.address_value ^ cfg.control_value;

	always_comb begin
		burst = '0;
		n     = '0;

		if (!hdr_sent) begin
			burst.bytes[0] = cfg.flag_value;
			burst.bytes[1] = cfg.address_value;
			burst.bytes[2] = cfg.control_value;
			burst.bytes[3] = check;
			n              = HDR_LEN;
		end

		if (item.byte_present) begin
			// flag wins when flag and escape hold the same value
			if (item.data_byte == cfg.flag_value) begin
				burst.bytes[n[IDX_W-1:0]]          = cfg.escape_value;
				burst.bytes[n[IDX_W-1:0] + 3'd1]   = cfg.flag_substitute;
				n                                  = n + CNT_W'(2);
			end else if (item.data_byte == cfg.escape_value) begin
				burst.bytes[n[IDX_W-1:0]]          = cfg.escape_value;
				burst.bytes[n[IDX_W-1:0] + 3'd1]   = cfg.escape_substitute;
				n                                  = n + CNT_W'(2);
			end else begin
				burst.bytes[n[IDX_W-1:0]]          = item.data_byte;
				n                                  = n + CNT_W'(1);
			end
		end

		if (item.last_byte) begin
			burst.bytes[n[IDX_W-1:0]]        = check;
			burst.bytes[n[IDX_W-1:0] + 3'd1] = cfg.flag_value;
			n                                = n + CNT_W'(2);
		end

		burst.nonempty      = item.byte_present | item.last_byte;
		burst.closes        = item.last_byte;
		burst.last_idx      = IDX_W'(n - CNT_W'(1));
		burst.hdr_sent_next = item.last_byte ? 1'b0 : (burst.nonempty | hdr_sent);
	end

endmodule

// File: design/byte_stuffing_frame_encoder.sv
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder
// HDLC-style byte stuffing framer for one information frame at a time.
// ----------------------------------------------------------------------------
// Each input request carries at most one payload byte and may mark the end of
// the frame. The first request of a frame is preceded by flag, address,
// control and check (address XOR control); flag and escape bytes in the
// payload go out as escape plus substitute; the closing request adds the check
// byte and a closing flag (frame_end set). A request with no byte and no last
// mark produces nothing. The output delivers one byte per cycle unless stalled,
// so a non-empty request puts out 1 to 8 bytes (up to 4 header + 2 stuffed + 2
// close); that single-byte output port sets the sustained rate. A request passes
// the input and burst registers before its first byte leaves. A one-entry input
// register lets the next request be taken while the current burst is still
// draining, and the burst register is reloaded in the same cycle its last byte
// leaves, so bursts follow each other with no idle cycle. Configuration is
// written through cfg_wr_en/cfg_index/cfg_data; the user must do so only while
// the block is idle, not enforced by the block; indexes above 5 are ignored.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder
	import bsfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  byte_t                cfg_data,
	bsfe_in_if.sink              in_ch,
	bsfe_out_if.source           out_ch
);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value        <= FLAG_RST;
			cfg_q.escape_value      <= ESCAPE_RST;
			cfg_q.flag_substitute   <= FLAG_SUB_RST;
			cfg_q.escape_substitute <= ESC_SUB_RST;
			cfg_q.address_value     <= ADDRESS_RST;
			cfg_q.control_value     <= CONTROL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FLAG:     cfg_q.flag_value        <= cfg_data;
				REG_ESCAPE:   cfg_q.escape_value      <= cfg_data;
				REG_FLAG_SUB: cfg_q.flag_substitute   <= cfg_data;
				REG_ESC_SUB:  cfg_q.escape_substitute <= cfg_data;
				REG_ADDRESS:  cfg_q.address_value     <= cfg_data;
				REG_CONTROL:  cfg_q.control_value     <= cfg_data;
				default:      ;
			endcase
		end
	end

	// stage 1: input register
	logic  s1_valid;
	item_t item_s1;

	// stage 2: burst register and read pointer
	logic             s2_valid;
	burst_t           burst_s2;
	logic [IDX_W-1:0] ptr_q;

	// frame state: header emitted, frame open
	logic hdr_sent_q;

	burst_t burst;
	logic   in_acc;
	logic   out_acc;
	logic   at_last;
	logic   s2_done;
	logic   s2_load;

	bsfe_build u_build (
		.cfg      (cfg_q),
		.item     (item_s1),
		.hdr_sent (hdr_sent_q),
		.burst    (burst)
	);

	assign at_last  = (ptr_q == burst_s2.last_idx);
	assign out_acc  = s2_valid & out_ch.ready;
	// burst register free now or after this cycle
	assign s2_done  = !s2_valid | (out_ch.ready & at_last);
	assign s2_load  = s1_valid & s2_done;
	assign in_ch.ready = !s1_valid | s2_done;
	assign in_acc   = in_ch.valid & in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= 1'b1;
		end else if (s2_load) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.data_byte    <= in_ch.data_byte;
			item_s1.byte_present <= in_ch.byte_present;
			item_s1.last_byte    <= in_ch.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid   <= 1'b0;
			ptr_q      <= '0;
			hdr_sent_q <= 1'b0;
		end else if (s2_load) begin
			// an empty request leaves the burst register empty
			s2_valid   <= burst.nonempty;
			ptr_q      <= '0;
			hdr_sent_q <= burst.hdr_sent_next;
		end else if (s2_done) begin
			s2_valid <= 1'b0;
		end else if (out_acc) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			burst_s2 <= burst;
		end
	end

	assign out_ch.valid     = s2_valid;
	assign out_ch.out_byte  = burst_s2.bytes[ptr_q];
	assign out_ch.run_last  = at_last;
	assign out_ch.frame_end = burst_s2.closes & at_last;

endmodule

// File: design/bsfe_checker.sv
// ----------------------------------------------------------------------------
// bsfe_checker
// Port-level assertions for the byte stuffing frame encoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfe_checker
	import bsfe_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  out_valid,
	input logic  out_ready,
	input byte_t out_byte,
	input logic  frame_end,
	input logic  run_last
);

	// stalled output keeps its byte
	`BSFE_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte), "output byte changed while stalled")
	// closing flag is always the last byte of its request
	`BSFE_ASSERT(a_end_last, clk, arst_n, out_valid && frame_end |-> run_last, "frame_end without run_last")
	// a burst drains without gaps
	`BSFE_ASSERT(a_no_gap, clk, arst_n, out_valid && out_ready && !run_last |=> out_valid, "gap inside a burst")
	// nothing comes out right after reset
	`BSFE_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> !out_valid, "output valid after reset")

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.frame_end (out_ch.frame_end),
	.run_last  (out_ch.run_last)
);
